[hdl/fplq_pkg.sv]
`default_nettype none

package fplq_pkg;

  // Request kinds on the input channel.
  localparam logic [1:0] KIND_SEND     = 2'd0;
  localparam logic [1:0] KIND_ANNOUNCE = 2'd1;
  localparam logic [1:0] KIND_REMOVE   = 2'd2;
  localparam logic [1:0] KIND_PROMOTE  = 2'd3;

  localparam logic [2:0] TOP_LEVEL = 3'd4;
  localparam logic [6:0] MAX_POPS  = 7'd64;

  // Operations broadcast to every cell of the chain.
  localparam logic [2:0] CELL_HOLD    = 3'd0;
  localparam logic [2:0] CELL_WRITE   = 3'd1;
  localparam logic [2:0] CELL_MARK_RM = 3'd2;
  localparam logic [2:0] CELL_MARK_PR = 3'd3;
  localparam logic [2:0] CELL_SORT    = 3'd4;
  localparam logic [2:0] CELL_SHIFT   = 3'd5;

  typedef struct packed {
    logic [7:0]  owner;
    logic [2:0]  level;
    logic [15:0] payload;
  } entry_t;

  typedef struct packed {
    logic   vld;
    logic   tag;
    entry_t ent;
  } cell_state_t;

  typedef struct packed {
    logic [2:0] op;
    logic       parity;
    logic       ann;
    entry_t     ent;
  } cell_ctrl_t;

  // Ordering key: empty cells sink to the tail. An announce orders by level,
  // highest first; remove and promote push tagged entries behind the rest.
  function automatic logic [3:0] sort_key(input cell_state_t s, input logic ann);
    logic [2:0] sub;
    sub = ann ? (TOP_LEVEL - s.ent.level) : {2'b00, s.tag};
    return {~s.vld, sub};
  endfunction

endpackage

`default_nettype wire

[hdl/fplq_cell.sv]
`default_nettype none

module fplq_cell (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire fplq_pkg::cell_ctrl_t ctrl,
  input  wire logic                 wr_sel,
  input  wire logic                 pos_odd,
  input  wire logic                 has_left,
  input  wire logic                 has_right,
  input  wire fplq_pkg::cell_state_t left_st,
  input  wire fplq_pkg::cell_state_t right_st,
  output fplq_pkg::cell_state_t      st
);

  fplq_pkg::cell_state_t st_next;
  logic                  pair_left;
  logic [3:0]            key_self;
  logic [3:0]            key_left;
  logic [3:0]            key_right;
  logic                  match;

  assign pair_left = (pos_odd == ctrl.parity);
  assign key_self  = fplq_pkg::sort_key(st, ctrl.ann);
  assign key_left  = fplq_pkg::sort_key(left_st, ctrl.ann);
  assign key_right = fplq_pkg::sort_key(right_st, ctrl.ann);
  assign match     = st.vld && (st.ent.owner == ctrl.ent.owner);

  // Next contents of this cell for the broadcast operation.
  always_comb begin
    st_next = st;
    case (ctrl.op)
      fplq_pkg::CELL_WRITE: begin
        if (wr_sel) begin
          st_next.vld = 1'b1;
          st_next.tag = 1'b0;
          st_next.ent = ctrl.ent;
        end
      end
      fplq_pkg::CELL_MARK_RM: begin
        st_next.tag = 1'b0;
        if (match) begin
          st_next.vld = 1'b0;
        end
      end
      fplq_pkg::CELL_MARK_PR: begin
        st_next.tag = 1'b0;
        if (match && (st.ent.level < fplq_pkg::TOP_LEVEL)) begin
          st_next.tag       = 1'b1;
          st_next.ent.level = st.ent.level + 3'd1;
        end
      end
      fplq_pkg::CELL_SORT: begin
        // Stable compare-exchange with the partner cell of this round.
        if (pair_left) begin
          if (has_right && (key_self > key_right)) begin
            st_next = right_st;
          end
        end else begin
          if (has_left && (key_left > key_self)) begin
            st_next = left_st;
          end
        end
      end
      fplq_pkg::CELL_SHIFT: begin
        if (has_right) begin
          st_next = right_st;
        end else begin
          st_next.vld = 1'b0;
        end
      end
      default: begin
        st_next = st;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    st.tag <= st_next.tag;
    st.ent <= st_next.ent;
    if (rst) begin
      st.vld <= 1'b0;
    end else begin
      st.vld <= st_next.vld;
    end
  end

endmodule

`default_nettype wire

[hdl/five_level_priority_queue.sv]
// Five-level priority message queue built as a chain of CAPACITY cells.
// Input channel (in_valid/in_ready) carries one request per beat: send,
// announce, remove owner or promote owner. Output channel (out_valid/
// out_ready) carries one popped message per beat, with last on the final
// message of an announce.
// A send writes the first empty cell. Remove and promote first mark the
// cells, then CAPACITY rounds of odd-even compare-exchange between
// neighbouring cells compact the chain. An announce runs CAPACITY sorting
// rounds (highest level first, stable) and then pops messages one after
// another, each pop shifting the whole chain one cell towards the head.
// The next request is taken once the current one is finished.
// When the receiver stalls, popping waits; the held beat stays unchanged.
// Reset empties the store and the output register; no clearing pass.
`default_nettype none

module five_level_priority_queue #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  kind,
  input  wire logic [7:0]  owner_id,
  input  wire logic [2:0]  level,
  input  wire logic [15:0] payload,
  input  wire logic [6:0]  count,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_owner,
  output logic [2:0]       out_level,
  output logic [15:0]      out_payload,
  output logic             last
);

  localparam int RW = $clog2(CAPACITY + 1);
  localparam logic [RW-1:0] LAST_RND = RW'(CAPACITY - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SORT = 2'd1;
  localparam logic [1:0] S_POP  = 2'd2;

  logic [1:0]            state;
  logic [RW-1:0]         rnd;
  logic                  ann;
  logic [6:0]            budget;
  fplq_pkg::cell_state_t st [CAPACITY];
  fplq_pkg::cell_ctrl_t  ctrl;
  logic [CAPACITY-1:0]   vld;
  logic [CAPACITY-1:0]   wr_sel;
  logic                  accept;
  logic                  full;
  logic                  pop_go;
  logic                  last_now;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign full     = vld[CAPACITY-1];
  assign pop_go   = (state == S_POP) && vld[0] && (budget != 7'd0) &&
                    (!out_valid || out_ready);
  assign last_now = (budget == 7'd1) || !vld[1];

  // Broadcast control for the chain.
  always_comb begin
    ctrl.op     = fplq_pkg::CELL_HOLD;
    ctrl.parity = rnd[0];
    ctrl.ann    = ann;
    ctrl.ent    = '{owner: owner_id, level: level, payload: payload};
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (kind)
            fplq_pkg::KIND_SEND: begin
              if ((level <= fplq_pkg::TOP_LEVEL) && !full) begin
                ctrl.op = fplq_pkg::CELL_WRITE;
              end
            end
            fplq_pkg::KIND_REMOVE:  ctrl.op = fplq_pkg::CELL_MARK_RM;
            fplq_pkg::KIND_PROMOTE: ctrl.op = fplq_pkg::CELL_MARK_PR;
            default:                ctrl.op = fplq_pkg::CELL_HOLD;
          endcase
        end
      end
      S_SORT: ctrl.op = fplq_pkg::CELL_SORT;
      S_POP: begin
        if (pop_go) begin
          ctrl.op = fplq_pkg::CELL_SHIFT;
        end
      end
      default: ctrl.op = fplq_pkg::CELL_HOLD;
    endcase
  end

  // The chain of cells; a send lands in the first empty cell.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign vld[i] = st[i].vld;
    if (i == 0) begin : g_head
      assign wr_sel[i] = !vld[i];
    end else begin : g_body
      assign wr_sel[i] = vld[i-1] && !vld[i];
    end
    fplq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .wr_sel   (wr_sel[i]),
      .pos_odd  (1'(i % 2)),
      .has_left ((i > 0) ? 1'b1 : 1'b0),
      .has_right((i < CAPACITY - 1) ? 1'b1 : 1'b0),
      .left_st  (st[(i > 0) ? i - 1 : 0]),
      .right_st (st[(i < CAPACITY - 1) ? i + 1 : CAPACITY - 1]),
      .st       (st[i])
    );
  end

  // Sequencer: sorting rounds, then pops for an announce.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rnd    <= '0;
      ann    <= 1'b0;
      budget <= 7'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rnd <= '0;
            if (kind == fplq_pkg::KIND_ANNOUNCE) begin
              if (count != 7'd0) begin
                state  <= S_SORT;
                ann    <= 1'b1;
                budget <= (count > fplq_pkg::MAX_POPS) ? fplq_pkg::MAX_POPS : count;
              end
            end else if ((kind == fplq_pkg::KIND_REMOVE) ||
                         (kind == fplq_pkg::KIND_PROMOTE)) begin
              state <= S_SORT;
              ann   <= 1'b0;
            end
          end
        end
        S_SORT: begin
          if (rnd == LAST_RND) begin
            state <= ann ? S_POP : S_IDLE;
          end else begin
            rnd <= rnd + 1'b1;
          end
        end
        S_POP: begin
          if (!vld[0] || (budget == 7'd0)) begin
            state <= S_IDLE;
          end else if (pop_go) begin
            budget <= budget - 7'd1;
            if (last_now) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Output register holding one beat.
  always_ff @(posedge clk) begin
    if (pop_go) begin
      out_owner   <= st[0].ent.owner;
      out_level   <= st[0].ent.level;
      out_payload <= st[0].ent.payload;
      last        <= last_now;
    end
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop_go) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // The store stays packed towards the head whenever the block is idle.
  assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> ((vld & (vld + 1'b1)) == '0))
    else $error("store not compact while idle");

  // An announce with a non-zero count closes the input in the cycle after it is accepted.
  assert property (@(posedge clk) disable iff (rst)
    (accept && (kind == fplq_pkg::KIND_ANNOUNCE) && (count != 7'd0)) |=> !in_ready)
    else $error("input open during announce");

  // Every pop moves the front message into the output register.
  assert property (@(posedge clk) disable iff (rst)
    pop_go |=> (out_valid && (out_owner == $past(st[0].ent.owner))))
    else $error("popped message lost");

endmodule

`default_nettype wire
